FILE: sv/ipv6ts_pkg.sv
// Shared types, character codes and helper functions for the IPv6 text serializer.
package ipv6ts_pkg;

  localparam int PieceCount = 8;
  localparam int PieceW     = 16;
  localparam int IdxW       = 3;
  localparam int CharW      = 7;

  localparam logic [CharW-1:0] ChOpenCode  = 7'h5B;  // '['
  localparam logic [CharW-1:0] ChCloseCode = 7'h5D;  // ']'
  localparam logic [CharW-1:0] ChColonCode = 7'h3A;  // ':'
  localparam logic [CharW-1:0] ChZeroCode  = 7'h30;  // '0'
  localparam logic [CharW-1:0] ChAlphaBase = 7'h57;  // 'a' - 10

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPEN,
    ST_PIECE,
    ST_DIGIT,
    ST_SEP,
    ST_DCOLON,
    ST_CLOSE
  } state_t;

  typedef enum logic [2:0] {
    CH_OPEN,
    CH_CLOSE,
    CH_COLON,
    CH_LEAD,
    CH_NIB
  } ch_sel_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_INC,
    IDX_JUMP
  } idx_op_t;

  typedef struct packed {
    logic    load;
    logic    emit;
    ch_sel_t sel;
    idx_op_t idx_op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic at_run;
    logic idx_first;
    logic idx_last;
    logic lead_zero;
    logic nib_zero;
    logic run_to_end;
  } status_t;

  typedef struct packed {
    logic          valid;
    logic [IdxW-1:0] start;
    logic [IdxW:0]   stop;
  } run_t;

  // First longest run of two or more zero pieces; bit i of zero is piece i.
  function automatic run_t find_zero_run(input logic [PieceCount-1:0] zero);
    run_t            r;
    logic [IdxW:0]   best_len;
    logic [IdxW:0]   cur_len;
    logic [IdxW-1:0] cur_start;
    r.valid   = 1'b0;
    r.start   = '0;
    r.stop    = '0;
    best_len  = (IdxW+1)'(1);
    cur_len   = '0;
    cur_start = '0;
    for (int i = 0; i < PieceCount; i++) begin
      if (zero[i]) begin
        if (cur_len == '0) cur_start = IdxW'(i);
        cur_len = cur_len + (IdxW+1)'(1);
      end else begin
        if (cur_len > best_len) begin
          best_len = cur_len;
          r.valid  = 1'b1;
          r.start  = cur_start;
        end
        cur_len = '0;
      end
    end
    if (cur_len > best_len) begin
      best_len = cur_len;
      r.valid  = 1'b1;
      r.start  = cur_start;
    end
    r.stop = {1'b0, r.start} + best_len;
    return r;
  endfunction

  // Index of the highest non-zero nibble, or zero for a zero piece.
  function automatic logic [1:0] lead_nibble(input logic [PieceW-1:0] v);
    logic [1:0] n;
    if (v[15:12] != 4'h0)     n = 2'd3;
    else if (v[11:8] != 4'h0) n = 2'd2;
    else if (v[7:4] != 4'h0)  n = 2'd1;
    else                      n = 2'd0;
    return n;
  endfunction

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] c;
    if (nib < 4'd10) c = ChZeroCode + {3'b000, nib};
    else             c = ChAlphaBase + {3'b000, nib};
    return c;
  endfunction

endpackage

FILE: sv/ipv6ts_dp.sv
// Datapath: address store, zero-run finder, piece and nibble counters, output register.
module ipv6ts_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ipv6ts_pkg::cmd_t                     cmd,
  output ipv6ts_pkg::status_t                  status,
  input  logic [ipv6ts_pkg::PieceW-1:0]        piece_0,
  input  logic [ipv6ts_pkg::PieceW-1:0]        piece_1,
  input  logic [ipv6ts_pkg::PieceW-1:0]        piece_2,
  input  logic [ipv6ts_pkg::PieceW-1:0]        piece_3,
  input  logic [ipv6ts_pkg::PieceW-1:0]        piece_4,
  input  logic [ipv6ts_pkg::PieceW-1:0]        piece_5,
  input  logic [ipv6ts_pkg::PieceW-1:0]        piece_6,
  input  logic [ipv6ts_pkg::PieceW-1:0]        piece_7,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ipv6ts_pkg::CharW-1:0]         text_char,
  output logic                                 last_char
);

  logic [ipv6ts_pkg::PieceW-1:0] pieces [ipv6ts_pkg::PieceCount];
  logic [ipv6ts_pkg::PieceW-1:0] in_pieces [ipv6ts_pkg::PieceCount];
  logic [ipv6ts_pkg::PieceCount-1:0] in_zero;
  ipv6ts_pkg::run_t              run;
  logic [ipv6ts_pkg::IdxW-1:0]   idx;
  logic [1:0]                    nib;
  logic [ipv6ts_pkg::PieceW-1:0] cur;
  logic [1:0]                    lead;
  logic [3:0]                    digit;
  logic [ipv6ts_pkg::CharW-1:0]  ch;

  assign in_pieces[0] = piece_0;
  assign in_pieces[1] = piece_1;
  assign in_pieces[2] = piece_2;
  assign in_pieces[3] = piece_3;
  assign in_pieces[4] = piece_4;
  assign in_pieces[5] = piece_5;
  assign in_pieces[6] = piece_6;
  assign in_pieces[7] = piece_7;

  always_comb begin
    for (int i = 0; i < ipv6ts_pkg::PieceCount; i++) begin
      in_zero[i] = (in_pieces[i] == '0);
    end
  end

  assign cur  = pieces[idx];
  assign lead = ipv6ts_pkg::lead_nibble(cur);

  always_comb begin
    digit = cur[{(cmd.sel == ipv6ts_pkg::CH_LEAD) ? lead : nib, 2'b00} +: 4];
  end

  always_comb begin
    unique case (cmd.sel) inside
      ipv6ts_pkg::CH_OPEN:  ch = ipv6ts_pkg::ChOpenCode;
      ipv6ts_pkg::CH_CLOSE: ch = ipv6ts_pkg::ChCloseCode;
      ipv6ts_pkg::CH_COLON: ch = ipv6ts_pkg::ChColonCode;
      ipv6ts_pkg::CH_LEAD,
      ipv6ts_pkg::CH_NIB:   ch = ipv6ts_pkg::hex_char(digit);
      default:              ch = ipv6ts_pkg::ChCloseCode;
    endcase
  end

  assign status.out_free   = !out_valid || out_ready;
  assign status.at_run     = run.valid && (idx == run.start);
  assign status.idx_first  = (idx == '0);
  assign status.idx_last   = (idx == ipv6ts_pkg::IdxW'(ipv6ts_pkg::PieceCount - 1));
  assign status.lead_zero  = (lead == 2'd0);
  assign status.nib_zero   = (nib == 2'd0);
  assign status.run_to_end = (run.stop == (ipv6ts_pkg::IdxW+1)'(ipv6ts_pkg::PieceCount));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < ipv6ts_pkg::PieceCount; i++) begin
        pieces[i] <= in_pieces[i];
      end
      run <= ipv6ts_pkg::find_zero_run(in_zero);
      idx <= '0;
    end else if (cmd.emit) begin
      unique case (cmd.idx_op)
        ipv6ts_pkg::IDX_INC:  idx <= idx + ipv6ts_pkg::IdxW'(1);
        ipv6ts_pkg::IDX_JUMP: idx <= run.stop[ipv6ts_pkg::IdxW-1:0];
        default:              idx <= idx;
      endcase
      // count down from the leading digit of the piece
      if (cmd.sel == ipv6ts_pkg::CH_LEAD) nib <= lead - 2'd1;
      else if (cmd.sel == ipv6ts_pkg::CH_NIB) nib <= nib - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      text_char <= ch;
      last_char <= (cmd.sel == ipv6ts_pkg::CH_CLOSE);
    end
  end

endmodule

FILE: sv/ipv6ts_ctrl.sv
// Controller: sequences the characters of one address text.
module ipv6ts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ipv6ts_pkg::status_t status,
  output ipv6ts_pkg::cmd_t    cmd
);

  ipv6ts_pkg::state_t state;
  ipv6ts_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipv6ts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.emit   = 1'b0;
    cmd.sel    = ipv6ts_pkg::CH_OPEN;
    cmd.idx_op = ipv6ts_pkg::IDX_HOLD;
    in_ready   = 1'b0;
    unique case (state)
      ipv6ts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ipv6ts_pkg::ST_OPEN;
        end
      end
      ipv6ts_pkg::ST_OPEN: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = ipv6ts_pkg::CH_OPEN;
          state_next = ipv6ts_pkg::ST_PIECE;
        end
      end
      ipv6ts_pkg::ST_PIECE: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.at_run) begin
            cmd.sel = ipv6ts_pkg::CH_COLON;
            if (status.idx_first) begin
              state_next = ipv6ts_pkg::ST_DCOLON;
            end else begin
              // drop the zero run
              cmd.idx_op = ipv6ts_pkg::IDX_JUMP;
              state_next = status.run_to_end ? ipv6ts_pkg::ST_CLOSE : ipv6ts_pkg::ST_PIECE;
            end
          end else begin
            cmd.sel = ipv6ts_pkg::CH_LEAD;
            if (!status.lead_zero) begin
              state_next = ipv6ts_pkg::ST_DIGIT;
            end else begin
              state_next = status.idx_last ? ipv6ts_pkg::ST_CLOSE : ipv6ts_pkg::ST_SEP;
            end
          end
        end
      end
      ipv6ts_pkg::ST_DIGIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = ipv6ts_pkg::CH_NIB;
          if (status.nib_zero) begin
            state_next = status.idx_last ? ipv6ts_pkg::ST_CLOSE : ipv6ts_pkg::ST_SEP;
          end
        end
      end
      ipv6ts_pkg::ST_SEP: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = ipv6ts_pkg::CH_COLON;
          cmd.idx_op = ipv6ts_pkg::IDX_INC;
          state_next = ipv6ts_pkg::ST_PIECE;
        end
      end
      ipv6ts_pkg::ST_DCOLON: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = ipv6ts_pkg::CH_COLON;
          cmd.idx_op = ipv6ts_pkg::IDX_JUMP;
          state_next = status.run_to_end ? ipv6ts_pkg::ST_CLOSE : ipv6ts_pkg::ST_PIECE;
        end
      end
      ipv6ts_pkg::ST_CLOSE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = ipv6ts_pkg::CH_CLOSE;
          state_next = ipv6ts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ipv6ts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/ipv6_text_serializer.sv
// Top level: IPv6 address in, bracketed canonical text out one character per word.
//
//   channel  signals                          width  direction
//   in       in_valid in_ready piece_0..7     16     address, eight pieces
//   out      out_valid out_ready text_char    7      ASCII character
//            last_char                        1      set on the closing bracket
//
// An address is taken in the idle state, then its text leaves one character per
// cycle through the output register while it is not stalled: 4 to 41 characters.
// The character sequencer advances only when the output register is free, so a
// stall on the output holds it in place. The next address is accepted once the
// closing bracket has been loaded into the output register.
// Reset clears the sequencer state and the output valid flag.
module ipv6_text_serializer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ipv6ts_pkg::PieceW-1:0] piece_0,
  input  logic [ipv6ts_pkg::PieceW-1:0] piece_1,
  input  logic [ipv6ts_pkg::PieceW-1:0] piece_2,
  input  logic [ipv6ts_pkg::PieceW-1:0] piece_3,
  input  logic [ipv6ts_pkg::PieceW-1:0] piece_4,
  input  logic [ipv6ts_pkg::PieceW-1:0] piece_5,
  input  logic [ipv6ts_pkg::PieceW-1:0] piece_6,
  input  logic [ipv6ts_pkg::PieceW-1:0] piece_7,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ipv6ts_pkg::CharW-1:0]  text_char,
  output logic                          last_char
);

  ipv6ts_pkg::cmd_t    cmd;
  ipv6ts_pkg::status_t status;

  ipv6ts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ipv6ts_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .piece_0   (piece_0),
    .piece_1   (piece_1),
    .piece_2   (piece_2),
    .piece_3   (piece_3),
    .piece_4   (piece_4),
    .piece_5   (piece_5),
    .piece_6   (piece_6),
    .piece_7   (piece_7),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .text_char (text_char),
    .last_char (last_char)
  );

endmodule
